/* hdl/asrd_pkg.sv */
package asrd_pkg;

	localparam int unsigned CHANNELS     = 10;
	localparam int unsigned MAP_ENTRIES  = 10;
	localparam int unsigned SAMPLE_BITS  = 12;

	localparam int unsigned UNIT_W       = 1;
	localparam int unsigned CHANNEL_W    = 4;
	localparam int unsigned SAMPLE_W     = 12;
	localparam int unsigned ADDR_W       = 12;
	localparam int unsigned SEQ_W        = 32;
	localparam int unsigned POS_W        = 4;
	localparam int unsigned LEN_W        = 4;
	localparam int unsigned FRAMES_W     = 9;
	localparam int unsigned MAP_W        = 40;
	localparam int unsigned CFG_DATA_W   = 40;
	localparam int unsigned CFG_INDEX_W  = 2;

	localparam logic [POS_W-1:0] UNUSED_POSITION = 4'hF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SCAN_LENGTH      = 2'd0,
		CFG_FRAMES_PER_BLOCK = 2'd1,
		CFG_CHANNEL_MAP      = 2'd2
	} cfg_index_t;

endpackage

/* hdl/asrd_record_if.sv */
interface asrd_record_if;
	logic                                  valid;
	logic                                  ready;
	logic [asrd_pkg::UNIT_W-1:0]           record_unit;
	logic [asrd_pkg::CHANNEL_W-1:0]        record_channel;
	logic [asrd_pkg::SAMPLE_W-1:0]         record_sample;

	modport source (output valid, record_unit, record_channel, record_sample, input ready);
	modport sink (input valid, record_unit, record_channel, record_sample, output ready);
endinterface

/* hdl/asrd_result_if.sv */
interface asrd_result_if;
	logic                             valid;
	logic                             ready;
	logic                             sample_written;
	logic [asrd_pkg::ADDR_W-1:0]      sample_address;
	logic [asrd_pkg::SAMPLE_W-1:0]    sample_value;
	logic                             block_done;
	logic                             completed_half;
	logic [asrd_pkg::SEQ_W-1:0]       block_sequence;

	modport source (output valid, sample_written, sample_address, sample_value, block_done,
		completed_half, block_sequence, input ready);
	modport sink (input valid, sample_written, sample_address, sample_value, block_done,
		completed_half, block_sequence, output ready);
endinterface

/* hdl/adc_scan_record_deframer_core.sv */
// an accepted record passes through the input register and then the result register
// throughput: one record per cycle while res.ready holds; the single frame/position counter update sets the rate
// ready stays high while the input register is empty or can move into the result register
// reset (arst_n low): counters, block sequence and both valid flags clear at once,
// scan_length and frames_per_block go to 1, channel_position_map to all ones
module adc_scan_record_deframer_core #(
	parameter int unsigned MAX_POSITIONS = 8,
	parameter int unsigned MAX_FRAMES    = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [asrd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [asrd_pkg::CFG_DATA_W-1:0]     cfg_data,
	asrd_record_if.sink                         rec,
	asrd_result_if.source                       res
);

	localparam int unsigned EXP_W = (MAX_POSITIONS > 2) ? $clog2(MAX_POSITIONS) : 1;
	localparam int unsigned FC_W  = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CMP_W = (FC_W + 1 > asrd_pkg::FRAMES_W) ? FC_W + 1
		: asrd_pkg::FRAMES_W;

	// configuration
	logic [asrd_pkg::LEN_W-1:0]    scan_length_q;
	logic [asrd_pkg::FRAMES_W-1:0] frames_per_block_q;
	logic [asrd_pkg::MAP_W-1:0]    channel_map_q;

	// tracking state
	logic                          fill_half_q;
	logic [FC_W-1:0]               frame_count_q;
	logic [EXP_W-1:0]              expected_q;
	logic                          done_half_q;
	logic [asrd_pkg::SEQ_W-1:0]    blocks_done_q;

	// input register
	logic                          valid_s1;
	logic [asrd_pkg::UNIT_W-1:0]   unit_s1;
	logic [asrd_pkg::CHANNEL_W-1:0] channel_s1;
	logic [asrd_pkg::SAMPLE_W-1:0] sample_s1;

	// result register
	logic                          valid_s2;
	logic                          written_s2;
	logic [asrd_pkg::ADDR_W-1:0]   address_s2;
	logic [asrd_pkg::SAMPLE_W-1:0] value_s2;
	logic                          done_s2;

	logic                          advance;
	logic [asrd_pkg::LEN_W-1:0]    len_eff;
	logic [CMP_W-1:0]              frames_eff;
	logic [asrd_pkg::POS_W-1:0]    position;
	logic                          in_range;
	logic                          accept;
	logic                          last_pos;
	logic [CMP_W-1:0]              frame_inc;
	logic                          half_done;
	logic [asrd_pkg::ADDR_W-1:0]   address;
	logic                          fill_half_d;
	logic [FC_W-1:0]               frame_count_d;
	logic [EXP_W-1:0]              expected_d;
	logic                          done_half_d;
	logic [asrd_pkg::SEQ_W-1:0]    blocks_done_d;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign rec.ready = !valid_s1 || advance;

	always_comb begin
		if (scan_length_q == '0) begin
			len_eff = asrd_pkg::LEN_W'(1);
		end else if (scan_length_q > asrd_pkg::LEN_W'(MAX_POSITIONS)) begin
			len_eff = asrd_pkg::LEN_W'(MAX_POSITIONS);
		end else begin
			len_eff = scan_length_q;
		end
	end

	always_comb begin
		if (frames_per_block_q == '0) begin
			frames_eff = CMP_W'(1);
		end else if (CMP_W'(frames_per_block_q) > CMP_W'(MAX_FRAMES)) begin
			frames_eff = CMP_W'(MAX_FRAMES);
		end else begin
			frames_eff = CMP_W'(frames_per_block_q);
		end
	end

	// map lookup, channels past the map read as position 0
	always_comb begin
		position = '0;
		for (int i = 0; i < asrd_pkg::MAP_ENTRIES; i++) begin
			if (channel_s1 == asrd_pkg::CHANNEL_W'(i)) begin
				position = channel_map_q[i*asrd_pkg::POS_W +: asrd_pkg::POS_W];
			end
		end
	end

	assign in_range = (unit_s1 == '0) && (channel_s1 < asrd_pkg::CHANNEL_W'(asrd_pkg::CHANNELS))
		&& (position != asrd_pkg::UNUSED_POSITION) && (position < len_eff);

	always_comb begin
		accept = in_range;
		if (in_range && (position != asrd_pkg::POS_W'(expected_q))) begin
			// resync: only position 0 restarts the frame
			accept = (position == '0);
		end
	end

	assign last_pos  = (position + asrd_pkg::POS_W'(1)) == len_eff;
	assign frame_inc = CMP_W'(frame_count_q) + CMP_W'(1);
	assign half_done = accept && last_pos && (frame_inc >= frames_eff);

	assign address = (fill_half_q ? asrd_pkg::ADDR_W'(frames_eff) * asrd_pkg::ADDR_W'(len_eff)
			: '0)
		+ asrd_pkg::ADDR_W'(frame_count_q) * asrd_pkg::ADDR_W'(len_eff)
		+ asrd_pkg::ADDR_W'(position);

	always_comb begin
		fill_half_d   = fill_half_q;
		frame_count_d = frame_count_q;
		expected_d    = expected_q;
		done_half_d   = done_half_q;
		blocks_done_d = blocks_done_q;
		// a dropped record that was out of step waits for position 0
		if (in_range && !accept) begin
			expected_d = '0;
		end
		if (accept) begin
			if (last_pos) begin
				expected_d = '0;
				if (half_done) begin
					done_half_d   = fill_half_q;
					fill_half_d   = !fill_half_q;
					frame_count_d = '0;
					blocks_done_d = blocks_done_q + asrd_pkg::SEQ_W'(1);
				end else begin
					frame_count_d = FC_W'(frame_inc);
				end
			end else begin
				expected_d = EXP_W'(position + asrd_pkg::POS_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_length_q      <= asrd_pkg::LEN_W'(1);
			frames_per_block_q <= asrd_pkg::FRAMES_W'(1);
			channel_map_q      <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				asrd_pkg::CFG_SCAN_LENGTH:
					scan_length_q <= cfg_data[asrd_pkg::LEN_W-1:0];
				asrd_pkg::CFG_FRAMES_PER_BLOCK:
					frames_per_block_q <= cfg_data[asrd_pkg::FRAMES_W-1:0];
				asrd_pkg::CFG_CHANNEL_MAP:
					channel_map_q <= cfg_data[asrd_pkg::MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_half_q   <= 1'b0;
			frame_count_q <= '0;
			expected_q    <= '0;
			done_half_q   <= 1'b0;
			blocks_done_q <= '0;
		end else if (advance) begin
			fill_half_q   <= fill_half_d;
			frame_count_q <= frame_count_d;
			expected_q    <= expected_d;
			done_half_q   <= done_half_d;
			blocks_done_q <= blocks_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec.ready) begin
			valid_s1 <= rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec.valid && rec.ready) begin
			unit_s1    <= rec.record_unit;
			channel_s1 <= rec.record_channel;
			sample_s1  <= rec.record_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			written_s2 <= accept;
			address_s2 <= accept ? address : '0;
			value_s2   <= accept ? (sample_s1 & asrd_pkg::SAMPLE_MASK) : '0;
			done_s2    <= half_done;
		end
	end

	// completed half and sequence come straight from state, already updated by this transaction
	assign res.valid          = valid_s2;
	assign res.sample_written = written_s2;
	assign res.sample_address = address_s2;
	assign res.sample_value   = value_s2;
	assign res.block_done     = done_s2;
	assign res.completed_half = done_half_q;
	assign res.block_sequence = blocks_done_q;

endmodule
